>>> rtl/skt_pkg.sv
// Shared types and codes for the sorted key table.
// Holds beat structs, opcode/status codes and controller-datapath command types.
// No dependencies.
package skt_pkg;

   localparam logic [1:0] OP_INSERT  = 2'd0;
   localparam logic [1:0] OP_DELETE  = 2'd1;
   localparam logic [1:0] OP_READOUT = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_EMPTY     = 2'd2;
   localparam logic [1:0] ST_FULL      = 2'd3;

   localparam int FILL_W = 5;

   typedef struct packed {
      logic [1:0]         opcode;
      logic signed [31:0] key;
      logic [31:0]        record_tag;
   } req_type;

   typedef struct packed {
      logic [1:0]          status;
      logic signed [31:0]  out_key;
      logic [31:0]         out_tag;
      logic [FILL_W-1:0]   fill_level;
      logic                last_of_run;
   } rsp_type;

   typedef enum logic [2:0] {
      IDX_HOLD,
      IDX_ZERO,
      IDX_COUNT,
      IDX_INC,
      IDX_DEC
   } idx_op_type;

   typedef enum logic [1:0] {
      CNT_HOLD,
      CNT_INC,
      CNT_DEC
   } cnt_op_type;

   typedef enum logic [1:0] {
      OFS_M1,
      OFS_0,
      OFS_P1
   } ofs_type;

   typedef enum logic {
      WR_FROM_MEM,
      WR_FROM_REQ
   } wr_src_type;

   typedef enum logic [1:0] {
      RSP_FROM_REQ,
      RSP_FROM_MEM,
      RSP_ZERO
   } rsp_src_type;

   typedef struct packed {
      logic        req_load;
      idx_op_type  idx_op;
      cnt_op_type  cnt_op;
      logic        rd_en;
      ofs_type     rd_ofs;
      logic        wr_en;
      wr_src_type  wr_src;
      logic        rsp_load;
      rsp_src_type rsp_src;
      logic [1:0]  rsp_status;
      logic        rsp_last;
   } cmd_type;

   typedef struct packed {
      logic count_zero;
      logic count_full;
      logic idx_is_one;
      logic idx_is_last;
      logic idx_next_last;
      logic key_less;
      logic key_equal;
      logic slot_free;
   } sts_type;

endpackage

>>> rtl/skt_datapath.sv
// Datapath of the sorted key table: request register, key/tag memories,
// index and count registers, response register. Uses skt_pkg.
module skt_datapath #(
   parameter int DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  skt_pkg::req_type  req_data,
   output skt_pkg::rsp_type  rsp_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  skt_pkg::cmd_type  cmd,
   output skt_pkg::sts_type  sts
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic signed [31:0] key_mem [DEPTH];
   logic [31:0]        tag_mem [DEPTH];

   skt_pkg::req_type   req_ff;
   logic signed [31:0] rd_key_ff;
   logic [31:0]        rd_tag_ff;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      rd_addr_full;
   logic [AW-1:0]      rd_addr, wr_addr;
   logic signed [31:0] wr_key;
   logic [31:0]        wr_tag;
   logic               rsp_valid_ff, rsp_valid_in;
   skt_pkg::rsp_type   rsp_ff, rsp_in;
   logic [CW:0]        idx_p1, idx_p2;

   always_comb begin
      case (cmd.idx_op)
         skt_pkg::IDX_ZERO:  idx_in = '0;
         skt_pkg::IDX_COUNT: idx_in = count_ff;
         skt_pkg::IDX_INC:   idx_in = idx_ff + CW'(1);
         skt_pkg::IDX_DEC:   idx_in = idx_ff - CW'(1);
         default:            idx_in = idx_ff;
      endcase
   end

   always_comb begin
      case (cmd.cnt_op)
         skt_pkg::CNT_INC: count_in = count_ff + CW'(1);
         skt_pkg::CNT_DEC: count_in = count_ff - CW'(1);
         default:          count_in = count_ff;
      endcase
   end

   // read address is relative to the index as it will be next cycle
   always_comb begin
      case (cmd.rd_ofs)
         skt_pkg::OFS_M1: rd_addr_full = idx_in - CW'(1);
         skt_pkg::OFS_P1: rd_addr_full = idx_in + CW'(1);
         default:         rd_addr_full = idx_in;
      endcase
   end

   assign rd_addr = rd_addr_full[AW-1:0];
   assign wr_addr = idx_ff[AW-1:0];
   assign wr_key  = (cmd.wr_src == skt_pkg::WR_FROM_REQ) ? req_ff.key : rd_key_ff;
   assign wr_tag  = (cmd.wr_src == skt_pkg::WR_FROM_REQ) ? req_ff.record_tag : rd_tag_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         key_mem[wr_addr] <= wr_key;
         tag_mem[wr_addr] <= wr_tag;
      end
      if (cmd.rd_en) begin
         rd_key_ff <= key_mem[rd_addr];
         rd_tag_ff <= tag_mem[rd_addr];
      end
   end

   always_comb begin
      rsp_in             = rsp_ff;
      rsp_in.status      = cmd.rsp_status;
      rsp_in.fill_level  = skt_pkg::FILL_W'(count_in);
      rsp_in.last_of_run = cmd.rsp_last;
      case (cmd.rsp_src)
         skt_pkg::RSP_FROM_MEM: begin
            rsp_in.out_key = rd_key_ff;
            rsp_in.out_tag = rd_tag_ff;
         end
         skt_pkg::RSP_FROM_REQ: begin
            rsp_in.out_key = req_ff.key;
            rsp_in.out_tag = '0;
         end
         default: begin
            rsp_in.out_key = '0;
            rsp_in.out_tag = '0;
         end
      endcase
   end

   assign sts.slot_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in  = cmd.rsp_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.req_load) begin
         req_ff <= req_data;
      end
      if (cmd.rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign idx_p1 = {1'b0, idx_ff} + (CW + 1)'(1);
   assign idx_p2 = {1'b0, idx_ff} + (CW + 1)'(2);

   assign sts.count_zero    = (count_ff == '0);
   assign sts.count_full    = (count_ff == CW'(DEPTH));
   assign sts.idx_is_one    = (idx_ff == CW'(1));
   assign sts.idx_is_last   = (idx_p1 == {1'b0, count_ff});
   assign sts.idx_next_last = (idx_p2 == {1'b0, count_ff});
   assign sts.key_less      = (rd_key_ff < req_ff.key);
   assign sts.key_equal     = (rd_key_ff == req_ff.key);

   assign rsp_data  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("record count beyond table depth");

   a_no_rw_collide: assert property (@(posedge clock) disable iff (reset)
      (cmd.wr_en && cmd.rd_en) |-> (wr_addr != rd_addr))
      else $error("shift reads the entry it writes");

   a_load_into_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> sts.slot_free)
      else $error("response overwritten before taken");
`endif

endmodule

>>> rtl/skt_control.sv
// Controller of the sorted key table: sequences insert, delete and readout
// over the datapath. Uses skt_pkg.
module skt_control (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [1:0]       req_opcode,
   input  skt_pkg::sts_type sts,
   output skt_pkg::cmd_type cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_INS_START,
      S_INS_SCAN,
      S_INS_PUT,
      S_DEL_START,
      S_DEL_FIND,
      S_DEL_SHIFT,
      S_RD_START,
      S_RD_DATA,
      S_EMIT
   } state_type;

   state_type            state_ff, state_in;
   logic [1:0]           status_ff, status_in;
   skt_pkg::rsp_src_type src_ff, src_in;
   skt_pkg::cnt_op_type  cnt_pend_ff, cnt_pend_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in    = state_ff;
      status_in   = status_ff;
      src_in      = src_ff;
      cnt_pend_in = cnt_pend_ff;

      cmd            = '0;
      cmd.idx_op     = skt_pkg::IDX_HOLD;
      cmd.cnt_op     = skt_pkg::CNT_HOLD;
      cmd.rd_ofs     = skt_pkg::OFS_0;
      cmd.wr_src     = skt_pkg::WR_FROM_MEM;
      cmd.rsp_src    = skt_pkg::RSP_FROM_REQ;
      cmd.rsp_status = skt_pkg::ST_OK;

      unique case (state_ff)
         S_IDLE: begin
            cmd.req_load = req_valid;
            if (req_valid) begin
               unique case (req_opcode)
                  skt_pkg::OP_INSERT:  state_in = S_INS_START;
                  skt_pkg::OP_DELETE:  state_in = S_DEL_START;
                  skt_pkg::OP_READOUT: state_in = S_RD_START;
                  default:             state_in = S_IDLE;
               endcase
            end
         end

         S_INS_START: begin
            src_in = skt_pkg::RSP_FROM_REQ;
            if (sts.count_full) begin
               status_in   = skt_pkg::ST_FULL;
               cnt_pend_in = skt_pkg::CNT_HOLD;
               state_in    = S_EMIT;
            end else begin
               cmd.idx_op = skt_pkg::IDX_COUNT;
               if (sts.count_zero) begin
                  state_in = S_INS_PUT;
               end else begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_ofs = skt_pkg::OFS_M1;
                  state_in   = S_INS_SCAN;
               end
            end
         end

         S_INS_SCAN: begin
            cmd.wr_en = 1'b1;
            if (sts.key_less) begin
               cmd.wr_src  = skt_pkg::WR_FROM_REQ;
               status_in   = skt_pkg::ST_OK;
               cnt_pend_in = skt_pkg::CNT_INC;
               state_in    = S_EMIT;
            end else begin
               cmd.idx_op = skt_pkg::IDX_DEC;
               if (sts.idx_is_one) begin
                  state_in = S_INS_PUT;
               end else begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_ofs = skt_pkg::OFS_M1;
               end
            end
         end

         S_INS_PUT: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_src  = skt_pkg::WR_FROM_REQ;
            status_in   = skt_pkg::ST_OK;
            cnt_pend_in = skt_pkg::CNT_INC;
            state_in    = S_EMIT;
         end

         S_DEL_START: begin
            src_in      = skt_pkg::RSP_FROM_REQ;
            cnt_pend_in = skt_pkg::CNT_HOLD;
            if (sts.count_zero) begin
               status_in = skt_pkg::ST_EMPTY;
               state_in  = S_EMIT;
            end else begin
               cmd.idx_op = skt_pkg::IDX_ZERO;
               cmd.rd_en  = 1'b1;
               state_in   = S_DEL_FIND;
            end
         end

         S_DEL_FIND: begin
            if (sts.key_equal) begin
               if (sts.idx_is_last) begin
                  status_in   = skt_pkg::ST_OK;
                  cnt_pend_in = skt_pkg::CNT_DEC;
                  state_in    = S_EMIT;
               end else begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_ofs = skt_pkg::OFS_P1;
                  state_in   = S_DEL_SHIFT;
               end
            end else if (sts.idx_is_last) begin
               status_in = skt_pkg::ST_NOT_FOUND;
               state_in  = S_EMIT;
            end else begin
               cmd.idx_op = skt_pkg::IDX_INC;
               cmd.rd_en  = 1'b1;
            end
         end

         S_DEL_SHIFT: begin
            cmd.wr_en  = 1'b1;
            cmd.idx_op = skt_pkg::IDX_INC;
            if (sts.idx_next_last) begin
               status_in   = skt_pkg::ST_OK;
               cnt_pend_in = skt_pkg::CNT_DEC;
               state_in    = S_EMIT;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_ofs = skt_pkg::OFS_P1;
            end
         end

         S_RD_START: begin
            if (sts.count_zero) begin
               src_in      = skt_pkg::RSP_ZERO;
               status_in   = skt_pkg::ST_EMPTY;
               cnt_pend_in = skt_pkg::CNT_HOLD;
               state_in    = S_EMIT;
            end else begin
               cmd.idx_op = skt_pkg::IDX_ZERO;
               cmd.rd_en  = 1'b1;
               state_in   = S_RD_DATA;
            end
         end

         S_RD_DATA: begin
            if (sts.slot_free) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_src  = skt_pkg::RSP_FROM_MEM;
               cmd.rsp_last = sts.idx_is_last;
               if (sts.idx_is_last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.idx_op = skt_pkg::IDX_INC;
                  cmd.rd_en  = 1'b1;
               end
            end
         end

         S_EMIT: begin
            if (sts.slot_free) begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_src    = src_ff;
               cmd.rsp_status = status_ff;
               cmd.rsp_last   = 1'b1;
               cmd.cnt_op     = cnt_pend_ff;
               state_in       = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         status_ff   <= skt_pkg::ST_OK;
         src_ff      <= skt_pkg::RSP_FROM_REQ;
         cnt_pend_ff <= skt_pkg::CNT_HOLD;
      end else begin
         state_ff    <= state_in;
         status_ff   <= status_in;
         src_ff      <= src_in;
         cnt_pend_ff <= cnt_pend_in;
      end
   end

endmodule

>>> rtl/sorted_key_table_top.sv
// Sorted key table, top level: up to DEPTH signed-key/tag records in key order.
// An insert into a full table and a delete from an empty one skip the memory
// walk. Readout gives one beat per cycle while rsp_ready is held high. Items
// are taken one at a time. Reset clears count and control; record memories
// are not cleared, only entries below the count are read.
module sorted_key_table_top #(
   parameter int DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  skt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output skt_pkg::rsp_type rsp_data
);

   // command/status link between sequencer and datapath
   skt_pkg::cmd_type cmd;
   skt_pkg::sts_type sts;

   // Sequencer: one state per walk step; insert walks down from the tail,
   // moving each larger-or-equal record up one slot; delete walks up from the
   // head to the first match, then pulls the rest down one slot.
   skt_control u_control (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_opcode (req_data.opcode),
      .sts        (sts),
      .cmd        (cmd)
   );

   // Datapath: memories with registered read, one move per cycle; the
   // response register lets a result beat wait while a new item is taken.
   skt_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule
